// File: hw/rtl/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
package bba_pkg;

    // Request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_SIZE = 2'd2;
    localparam logic [1:0] ST_ADDR = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_LMIN   = 2'd0;
    localparam logic [1:0] REG_KCNT   = 2'd1;
    localparam logic [1:0] REG_USABLE = 2'd2;
    localparam logic [1:0] REG_BASE   = 2'd3;

    // Width of a size class number and clamp limits
    localparam int CLS_W = 4;
    localparam logic [4:0] LMIN_LO = 5'd4;
    localparam logic [4:0] LMIN_HI = 5'd24;
    localparam logic [CLS_W-1:0] KCNT_LO = 4'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DEC,
        S_POP,
        S_POPGO,
        S_RCYGO,
        S_ROWRD,
        S_AROW,
        S_SPLIT,
        S_PUSH1,
        S_PUSH2,
        S_FROW,
        S_MERGE,
        S_RMWT,
        S_RMGO,
        S_WB
    } t_state;

    // Request decode results
    typedef struct packed {
        logic             size_ok;
        logic [CLS_W-1:0] cls;
        logic             addr_bad;
        logic             misalign;
    } t_dec;

endpackage

// File: hw/rtl/bba_ram.sv
// Generic single write port, single read port RAM with registered read.
module bba_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write, and read the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/bba_decode.sv
// Request decode: size class, free address range and alignment checks.
module bba_decode #(
    parameter int MAX_CHUNKS  = 64,
    parameter int MAX_CLASSES = 8,
    localparam int CB = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
    localparam int CW = $clog2(MAX_CHUNKS + 1),
    localparam int UW = MAX_CLASSES - 1
) (
    input  logic [4:0]                  i_lmin,
    input  logic [bba_pkg::CLS_W-1:0]   i_kcnt,
    input  logic [31:0]                 i_size,
    input  logic [31:0]                 i_addr,
    input  logic [31:0]                 i_base,
    input  logic [CW-1:0]               i_fresh,
    output bba_pkg::t_dec               o_dec,
    output logic [CB-1:0]               o_chunk,
    output logic [UW-1:0]               o_u
);
    import bba_pkg::*;

    logic             found;
    logic [CLS_W-1:0] cls;
    logic [36:0]      size_x;
    logic [31:0]      d;
    logic [31:0]      hi;
    logic [5:0]       top;
    logic [31:0]      umask;

    // Smallest class that holds the size
    always_comb begin
        found  = 1'b0;
        cls    = '0;
        size_x = {5'd0, i_size};
        for (int c = 0; c < MAX_CLASSES; c++) begin
            if (!found && (CLS_W'(c) < i_kcnt) &&
                ((37'd1 << (6'(i_lmin) + 6'(c))) >= size_x)) begin
                found = 1'b1;
                cls   = CLS_W'(c);
            end
        end
    end

    // Chunk and offset of the freed address
    always_comb begin
        d     = i_addr - i_base;
        top   = 6'(i_lmin) + 6'(i_kcnt) - 6'd1;
        hi    = d >> top;
        umask = (32'd1 << (i_kcnt - 4'd1)) - 32'd1;
    end

    assign o_dec.size_ok  = found && (size_x >= (37'd1 << i_lmin));
    assign o_dec.cls      = cls;
    assign o_dec.addr_bad = (i_addr < i_base) || (hi >= 32'(i_fresh));
    assign o_dec.misalign =
        ({5'd0, d} & ((37'd1 << (6'(i_lmin) + 6'(cls))) - 37'd1)) != 37'd0;
    assign o_chunk = hi[CB-1:0];
    assign o_u     = UW'((d >> i_lmin) & umask);
endmodule

// File: hw/rtl/bba_ctrl.sv
// Allocator sequencer: free lists, split and merge walks, chunk bookkeeping.
module bba_ctrl #(
    parameter int MAX_CHUNKS  = 64,
    parameter int MAX_CLASSES = 8,
    localparam int CB = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
    localparam int CW = $clog2(MAX_CHUNKS + 1),
    localparam int UW = MAX_CLASSES - 1,
    localparam int SB = CB + UW,
    localparam int NW = 1 << MAX_CLASSES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           i_func,
    input  logic [31:0]    i_request_size,
    input  logic [31:0]    i_block_address,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data,
    output logic           o_done,
    output logic [31:0]    o_granted_address,
    output logic [1:0]     o_status,
    output logic [6:0]     o_chunks_in_use,
    // node row memory, one row per chunk
    output logic           o_row_we,
    output logic [CB-1:0]  o_row_waddr,
    output logic [NW-1:0]  o_row_wdata,
    output logic [CB-1:0]  o_row_raddr,
    input  logic [NW-1:0]  i_row_rdata,
    // list next links
    output logic           o_nx_we,
    output logic [SB-1:0]  o_nx_waddr,
    output logic [SB-1:0]  o_nx_wdata,
    output logic [SB-1:0]  o_nx_raddr,
    input  logic [SB-1:0]  i_nx_rdata,
    // list prev links
    output logic           o_pv_we,
    output logic [SB-1:0]  o_pv_waddr,
    output logic [SB-1:0]  o_pv_wdata,
    output logic [SB-1:0]  o_pv_raddr,
    input  logic [SB-1:0]  i_pv_rdata,
    // recycled chunk links
    output logic           o_rc_we,
    output logic [CB-1:0]  o_rc_waddr,
    output logic [CB-1:0]  o_rc_wdata,
    output logic [CB-1:0]  o_rc_raddr,
    input  logic [CB-1:0]  i_rc_rdata
);
    import bba_pkg::*;

    localparam int JW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

    t_state           r_state, n_state;
    logic             r_func, n_func;
    logic [31:0]      r_size, n_size;
    logic [31:0]      r_addr, n_addr;
    logic [4:0]       r_lmin, n_lmin;
    logic [3:0]       r_kcnt, n_kcnt;
    logic [6:0]       r_usable, n_usable;
    logic [31:0]      r_base, n_base;
    logic [SB-1:0]    r_head [MAX_CLASSES];
    logic [SB-1:0]    n_head [MAX_CLASSES];
    logic [MAX_CLASSES-1:0] r_hvalid, n_hvalid;
    logic [CB-1:0]    r_rhead, n_rhead;
    logic [CW-1:0]    r_rcount, n_rcount;
    logic [CW-1:0]    r_fresh, n_fresh;
    logic [CW-1:0]    r_used, n_used;
    logic [CB-1:0]    r_clr, n_clr;
    logic [CLS_W-1:0] r_c, n_c;
    logic [CLS_W-1:0] r_j, n_j;
    logic [CB-1:0]    r_chunk, n_chunk;
    logic [UW-1:0]    r_u, n_u;
    logic [NW-1:0]    r_row, n_row;
    logic [SB-1:0]    r_slot, n_slot;
    logic [SB-1:0]    r_ps, n_ps;
    logic [CLS_W-1:0] r_pc, n_pc;
    logic [SB-1:0]    r_ph, n_ph;
    logic             r_mis, n_mis;
    logic             r_done, n_done;
    logic [31:0]      r_gaddr, n_gaddr;
    logic [1:0]       r_status, n_status;
    logic [6:0]       r_cio, n_cio;

    logic [4:0]       lm;
    logic [CLS_W-1:0] k;
    logic [31:0]      usable_eff;
    logic [5:0]       top;
    t_dec             dec;
    logic [CB-1:0]    dec_chunk;
    logic [UW-1:0]    dec_u;
    logic             jfound;
    logic [CLS_W-1:0] jsel;

    // Tree node index of class c at shifted offset q within a chunk row
    function automatic logic [MAX_CLASSES-1:0] f_node(
        input logic [CLS_W-1:0]       kk,
        input logic [CLS_W-1:0]       c,
        input logic [MAX_CLASSES-1:0] q
    );
        logic [MAX_CLASSES:0] first;
        first = ((MAX_CLASSES+1)'(1) << (kk - 4'd1 - c)) - (MAX_CLASSES+1)'(1);
        return MAX_CLASSES'(first + {1'b0, q});
    endfunction

    // Clamped configuration
    always_comb begin
        lm = (r_lmin < LMIN_LO) ? LMIN_LO : ((r_lmin > LMIN_HI) ? LMIN_HI : r_lmin);
        if (r_kcnt < KCNT_LO) begin
            k = KCNT_LO;
        end else if (32'(r_kcnt) > 32'(MAX_CLASSES)) begin
            k = CLS_W'(MAX_CLASSES);
        end else begin
            k = r_kcnt;
        end
        usable_eff = (32'(r_usable) > 32'(MAX_CHUNKS)) ? 32'(MAX_CHUNKS) : 32'(r_usable);
        top = 6'(lm) + 6'(k) - 6'd1;
    end

    bba_decode #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .MAX_CLASSES(MAX_CLASSES)
    ) u_decode (
        .i_lmin (lm),
        .i_kcnt (k),
        .i_size (r_size),
        .i_addr (r_addr),
        .i_base (r_base),
        .i_fresh(r_fresh),
        .o_dec  (dec),
        .o_chunk(dec_chunk),
        .o_u    (dec_u)
    );

    // Nearest nonempty class at or above the request class
    always_comb begin
        jfound = 1'b0;
        jsel   = '0;
        for (int j = 0; j < MAX_CLASSES; j++) begin
            if (!jfound && (CLS_W'(j) >= dec.cls) && (CLS_W'(j) < k) && r_hvalid[j]) begin
                jfound = 1'b1;
                jsel   = CLS_W'(j);
            end
        end
    end

    // Read addresses follow the working registers
    assign o_row_raddr = r_chunk;
    assign o_nx_raddr  = r_slot;
    assign o_pv_raddr  = r_slot;
    assign o_rc_raddr  = r_rhead;

    // Next state, memory accesses and bookkeeping
    always_comb begin
        logic [SB-1:0]          s_n;
        logic [SB-1:0]          s_p;
        logic                   hp;
        logic                   hn;
        logic [MAX_CLASSES-1:0] nd;
        logic [MAX_CLASSES-1:0] ch1;
        logic [MAX_CLASSES-1:0] ch2;
        logic                   whole;
        logic [CLS_W-1:0]       cn;
        logic [UW-1:0]          un;
        t_state                 ret;

        n_state  = r_state;
        n_func   = r_func;
        n_size   = r_size;
        n_addr   = r_addr;
        n_lmin   = r_lmin;
        n_kcnt   = r_kcnt;
        n_usable = r_usable;
        n_base   = r_base;
        n_head   = r_head;
        n_hvalid = r_hvalid;
        n_rhead  = r_rhead;
        n_rcount = r_rcount;
        n_fresh  = r_fresh;
        n_used   = r_used;
        n_clr    = r_clr;
        n_c      = r_c;
        n_j      = r_j;
        n_chunk  = r_chunk;
        n_u      = r_u;
        n_row    = r_row;
        n_slot   = r_slot;
        n_ps     = r_ps;
        n_pc     = r_pc;
        n_ph     = r_ph;
        n_mis    = r_mis;
        n_done   = 1'b0;
        n_gaddr  = r_gaddr;
        n_status = r_status;
        n_cio    = r_cio;

        o_row_we    = 1'b0;
        o_row_waddr = r_chunk;
        o_row_wdata = r_row;
        o_nx_we     = 1'b0;
        o_nx_waddr  = r_ps;
        o_nx_wdata  = r_ps;
        o_pv_we     = 1'b0;
        o_pv_waddr  = r_ps;
        o_pv_wdata  = r_ps;
        o_rc_we     = 1'b0;
        o_rc_waddr  = r_chunk;
        o_rc_wdata  = r_rhead;

        s_n   = i_nx_rdata;
        s_p   = i_pv_rdata;
        hp    = (s_p != r_slot);
        hn    = (s_n != r_slot);
        nd    = f_node(k, r_c, MAX_CLASSES'(r_u >> r_c));
        ch1   = f_node(k, r_c - 4'd1, MAX_CLASSES'(r_u >> (r_c - 4'd1)));
        ch2   = f_node(k, r_c - 4'd1, MAX_CLASSES'(r_u >> (r_c - 4'd1)) + 1'b1);
        whole = i_row_rdata[nd] && ((r_c == '0) || (!i_row_rdata[ch1] && !i_row_rdata[ch2]));
        cn    = r_c + 4'd1;
        un    = r_u & ~(UW'(1) << r_c);
        ret   = (r_func == FUNC_ALLOC) ? S_SPLIT : S_WB;

        // Configuration writes, taken in any state
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LMIN:   n_lmin   = i_cfg_data[4:0];
                REG_KCNT:   n_kcnt   = i_cfg_data[3:0];
                REG_USABLE: n_usable = i_cfg_data[6:0];
                REG_BASE:   n_base   = i_cfg_data;
                default:    n_base   = r_base;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                o_row_we    = 1'b1;
                o_row_waddr = r_clr;
                o_row_wdata = '0;
                n_clr       = r_clr + 1'b1;
                if (r_clr == CB'(MAX_CHUNKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_func  = i_func;
                    n_size  = i_request_size;
                    n_addr  = i_block_address;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_c   = dec.cls;
                n_mis = dec.misalign;
                if (r_func == FUNC_ALLOC) begin
                    if (!dec.size_ok) begin
                        n_done = 1'b1; n_status = ST_SIZE; n_gaddr = '0;
                        n_cio = 7'(r_used); n_state = S_IDLE;
                    end else if (jfound) begin
                        n_j     = jsel;
                        n_slot  = r_head[jsel[JW-1:0]];
                        n_state = S_POP;
                    end else if (r_rcount != '0) begin
                        n_chunk  = r_rhead;
                        n_u      = '0;
                        n_j      = k - 4'd1;
                        n_rcount = r_rcount - 1'b1;
                        n_used   = r_used + 1'b1;
                        n_state  = S_RCYGO;
                    end else if (32'(r_fresh) < usable_eff) begin
                        n_chunk = r_fresh[CB-1:0];
                        n_u     = '0;
                        n_j     = k - 4'd1;
                        n_fresh = r_fresh + 1'b1;
                        n_used  = r_used + 1'b1;
                        n_state = S_ROWRD;
                    end else begin
                        n_done = 1'b1; n_status = ST_OOM; n_gaddr = '0;
                        n_cio = 7'(r_used); n_state = S_IDLE;
                    end
                end else begin
                    if (dec.addr_bad) begin
                        n_done = 1'b1; n_status = ST_ADDR; n_gaddr = '0;
                        n_cio = 7'(r_used); n_state = S_IDLE;
                    end else if (!dec.size_ok) begin
                        n_done = 1'b1; n_status = ST_SIZE; n_gaddr = '0;
                        n_cio = 7'(r_used); n_state = S_IDLE;
                    end else begin
                        n_chunk = dec_chunk;
                        n_u     = dec_u;
                        n_state = S_ROWRD;
                    end
                end
            end
            S_POP: begin
                // next link of the head is being read
                n_state = S_POPGO;
            end
            S_POPGO: begin
                if (s_n != r_slot) begin
                    n_head[r_j[JW-1:0]] = s_n;
                    o_pv_we    = 1'b1;
                    o_pv_waddr = s_n;
                    o_pv_wdata = s_n;
                end else begin
                    n_hvalid[r_j[JW-1:0]] = 1'b0;
                end
                n_chunk = r_slot[SB-1:UW];
                n_u     = r_slot[UW-1:0];
                n_state = S_ROWRD;
            end
            S_RCYGO: begin
                n_rhead = i_rc_rdata;
                n_state = S_ROWRD;
            end
            S_ROWRD: begin
                n_state = (r_func == FUNC_ALLOC) ? S_AROW : S_FROW;
            end
            S_AROW: begin
                n_row = i_row_rdata;
                n_row[f_node(k, r_j, MAX_CLASSES'(r_u >> r_j))] = 1'b1;
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                // one split step: mark lower half, push upper buddy
                if (r_j > r_c) begin
                    n_j = r_j - 4'd1;
                    n_row[f_node(k, r_j - 4'd1, MAX_CLASSES'(r_u >> (r_j - 4'd1)))] = 1'b1;
                    n_ps    = {r_chunk, UW'(r_u + (UW'(1) << (r_j - 4'd1)))};
                    n_pc    = r_j - 4'd1;
                    n_state = S_PUSH1;
                end else begin
                    n_state = S_WB;
                end
            end
            S_PUSH1: begin
                o_nx_we    = 1'b1;
                o_nx_waddr = r_ps;
                o_nx_wdata = r_hvalid[r_pc[JW-1:0]] ? r_head[r_pc[JW-1:0]] : r_ps;
                o_pv_we    = 1'b1;
                o_pv_waddr = r_ps;
                o_pv_wdata = r_ps;
                n_ph       = r_head[r_pc[JW-1:0]];
                n_head[r_pc[JW-1:0]]   = r_ps;
                n_hvalid[r_pc[JW-1:0]] = 1'b1;
                n_state = r_hvalid[r_pc[JW-1:0]] ? S_PUSH2 : ret;
            end
            S_PUSH2: begin
                o_pv_we    = 1'b1;
                o_pv_waddr = r_ph;
                o_pv_wdata = r_ps;
                n_state    = ret;
            end
            S_FROW: begin
                if (r_mis || !whole) begin
                    n_done = 1'b1; n_status = ST_ADDR; n_gaddr = '0;
                    n_cio = 7'(r_used); n_state = S_IDLE;
                end else begin
                    n_row     = i_row_rdata;
                    n_row[nd] = 1'b0;
                    n_state   = S_MERGE;
                end
            end
            S_MERGE: begin
                if (r_c >= k - 4'd1) begin
                    // whole chunk free: back on the recycled list
                    o_rc_we    = 1'b1;
                    o_rc_waddr = r_chunk;
                    o_rc_wdata = r_rhead;
                    n_rhead    = r_chunk;
                    n_rcount   = r_rcount + 1'b1;
                    if (r_used != '0) begin
                        n_used = r_used - 1'b1;
                    end
                    n_state = S_WB;
                end else if (!r_row[f_node(k, r_c,
                        MAX_CLASSES'((r_u ^ (UW'(1) << r_c)) >> r_c))]) begin
                    n_slot  = {r_chunk, UW'(r_u ^ (UW'(1) << r_c))};
                    n_state = S_RMWT;
                end else begin
                    n_ps    = {r_chunk, r_u};
                    n_pc    = r_c;
                    n_state = S_PUSH1;
                end
            end
            S_RMWT: begin
                // buddy links are being read
                n_state = S_RMGO;
            end
            S_RMGO: begin
                // unlink buddy, then step up one class
                if (hp) begin
                    o_nx_we    = 1'b1;
                    o_nx_waddr = s_p;
                    o_nx_wdata = hn ? s_n : s_p;
                end else if (hn) begin
                    n_head[r_c[JW-1:0]] = s_n;
                end else begin
                    n_hvalid[r_c[JW-1:0]] = 1'b0;
                end
                if (hn) begin
                    o_pv_we    = 1'b1;
                    o_pv_waddr = s_n;
                    o_pv_wdata = hp ? s_p : s_n;
                end
                n_u = un;
                n_c = cn;
                n_row[f_node(k, cn, MAX_CLASSES'(un >> cn))] = 1'b0;
                n_state = S_MERGE;
            end
            S_WB: begin
                o_row_we    = 1'b1;
                o_row_waddr = r_chunk;
                o_row_wdata = r_row;
                n_done      = 1'b1;
                n_status    = ST_OK;
                n_gaddr     = (r_func == FUNC_ALLOC) ?
                              (r_base + (32'(r_chunk) << top) + (32'(r_u) << lm)) : '0;
                n_cio       = 7'(r_used);
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lmin   <= 5'd4;
            r_kcnt   <= 4'd8;
            r_usable <= 7'd64;
            r_base   <= '0;
            r_hvalid <= '0;
            r_rhead  <= '0;
            r_rcount <= '0;
            r_fresh  <= '0;
            r_used   <= '0;
            r_clr    <= '0;
            r_done   <= 1'b0;
        end else begin
            r_lmin   <= n_lmin;
            r_kcnt   <= n_kcnt;
            r_usable <= n_usable;
            r_base   <= n_base;
            r_hvalid <= n_hvalid;
            r_rhead  <= n_rhead;
            r_rcount <= n_rcount;
            r_fresh  <= n_fresh;
            r_used   <= n_used;
            r_clr    <= n_clr;
            r_done   <= n_done;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_size   <= n_size;
        r_addr   <= n_addr;
        r_head   <= n_head;
        r_c      <= n_c;
        r_j      <= n_j;
        r_chunk  <= n_chunk;
        r_u      <= n_u;
        r_row    <= n_row;
        r_slot   <= n_slot;
        r_ps     <= n_ps;
        r_pc     <= n_pc;
        r_ph     <= n_ph;
        r_mis    <= n_mis;
        r_gaddr  <= n_gaddr;
        r_status <= n_status;
        r_cio    <= n_cio;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_granted_address = r_gaddr;
    assign o_status          = r_status;
    assign o_chunks_in_use   = r_cio;
endmodule

// File: hw/rtl/buddy_block_allocator.sv
// Binary buddy allocator: node rows, list links and recycled-chunk links in RAM.
// An allocate takes a block from a free list, a recycled chunk or a fresh chunk, then
// splits it down one class per step, pushing each upper buddy; a free merges upward while
// the buddy is free, then pushes the block or recycles the whole chunk; errors end early.
// One word at a time: busy drops in the idle state after each result; o_done pulses once.
// Reset is synchronous, active low; the node-row RAM is then cleared one row a cycle.
module buddy_block_allocator #(
    parameter int MAX_CHUNKS  = 64,
    parameter int MAX_CLASSES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_block_address,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [31:0] o_granted_address,
    output logic [1:0]  o_status,
    output logic [6:0]  o_chunks_in_use
);
    localparam int CB = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int UW = MAX_CLASSES - 1;
    localparam int SB = CB + UW;
    localparam int NW = 1 << MAX_CLASSES;

    logic          row_we;
    logic [CB-1:0] row_waddr, row_raddr;
    logic [NW-1:0] row_wdata, row_rdata;
    logic          nx_we, pv_we;
    logic [SB-1:0] nx_waddr, nx_wdata, nx_raddr, nx_rdata;
    logic [SB-1:0] pv_waddr, pv_wdata, pv_raddr, pv_rdata;
    logic          rc_we;
    logic [CB-1:0] rc_waddr, rc_wdata, rc_raddr, rc_rdata;

    bba_ctrl #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .MAX_CLASSES(MAX_CLASSES)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_request_size   (i_request_size),
        .i_block_address  (i_block_address),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_granted_address(o_granted_address),
        .o_status         (o_status),
        .o_chunks_in_use  (o_chunks_in_use),
        .o_row_we         (row_we),
        .o_row_waddr      (row_waddr),
        .o_row_wdata      (row_wdata),
        .o_row_raddr      (row_raddr),
        .i_row_rdata      (row_rdata),
        .o_nx_we          (nx_we),
        .o_nx_waddr       (nx_waddr),
        .o_nx_wdata       (nx_wdata),
        .o_nx_raddr       (nx_raddr),
        .i_nx_rdata       (nx_rdata),
        .o_pv_we          (pv_we),
        .o_pv_waddr       (pv_waddr),
        .o_pv_wdata       (pv_wdata),
        .o_pv_raddr       (pv_raddr),
        .i_pv_rdata       (pv_rdata),
        .o_rc_we          (rc_we),
        .o_rc_waddr       (rc_waddr),
        .o_rc_wdata       (rc_wdata),
        .o_rc_raddr       (rc_raddr),
        .i_rc_rdata       (rc_rdata)
    );

    // In-use bits, one row per chunk tree
    bba_ram #(.W(NW), .D(1 << CB)) u_row_ram (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(row_waddr), .i_wdata(row_wdata),
        .i_raddr(row_raddr), .o_rdata(row_rdata)
    );

    // Free list next links
    bba_ram #(.W(SB), .D(1 << SB)) u_next_ram (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(nx_raddr), .o_rdata(nx_rdata)
    );

    // Free list prev links
    bba_ram #(.W(SB), .D(1 << SB)) u_prev_ram (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_raddr(pv_raddr), .o_rdata(pv_rdata)
    );

    // Recycled chunk links
    bba_ram #(.W(CB), .D(1 << CB)) u_rcy_ram (
        .i_clk(i_clk), .i_we(rc_we), .i_waddr(rc_waddr), .i_wdata(rc_wdata),
        .i_raddr(rc_raddr), .o_rdata(rc_rdata)
    );
endmodule

// File: verif/tb_buddy_block_allocator.sv
// Self-checking testbench for the buddy block allocator: directed table, then random phases.
`timescale 1ns / 100ps

module tb_buddy_block_allocator;
    import bba_pkg::*;

    localparam int CHUNKS   = 64;
    localparam int CLASSES  = 8;
    localparam int NODE_ROW = 256;
    localparam int SLOT_ROW = 128;
    localparam int SLOTS    = CHUNKS * SLOT_ROW;
    localparam int LIMIT    = 400000;

    typedef struct {
        logic [31:0] addr;
        logic [1:0]  status;
        logic [6:0]  chunks;
    } t_grant;

    typedef struct {
        logic [31:0] addr;
        int          cls;
    } t_live_blk;

    typedef struct {
        logic        f;
        logic [31:0] size;
        logic [31:0] addr;
        bit          typed;
        t_grant      g;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_func;
    logic [31:0] i_request_size;
    logic [31:0] i_block_address;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        o_done;
    logic [31:0] o_granted_address;
    logic [1:0]  o_status;
    logic [6:0]  o_chunks_in_use;

    t_grant    grant_q[$];
    t_live_blk live_q[$];
    int        errors = 0;
    int        cycles = 0;
    bit        calm = 1'b0;

    // allocator state mirror
    bit          node_used[CHUNKS*NODE_ROW];
    int unsigned link_next[SLOTS];
    int unsigned link_prev[SLOTS];
    int unsigned cls_head[CLASSES];
    bit          cls_valid[CLASSES];
    int unsigned rcy_head, rcy_cnt, fresh_idx, used_cnt;
    int unsigned rcy_link[CHUNKS];
    logic [4:0]  m_lmin   = 5'd4;
    logic [3:0]  m_kcnt   = 4'd8;
    logic [6:0]  m_usable = 7'd64;
    logic [31:0] m_base   = 32'd0;

    buddy_block_allocator u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_func            (i_func),
        .i_request_size    (i_request_size),
        .i_block_address   (i_block_address),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_done            (o_done),
        .o_granted_address (o_granted_address),
        .o_status          (o_status),
        .o_chunks_in_use   (o_chunks_in_use)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int eff_lm();
        return (m_lmin < 4) ? 4 : ((m_lmin > 24) ? 24 : int'(m_lmin));
    endfunction

    function automatic int eff_k();
        return (m_kcnt < 2) ? 2 : ((m_kcnt > CLASSES) ? CLASSES : int'(m_kcnt));
    endfunction

    function automatic int node_ix(int unsigned chunk, int c, longint unsigned off, int k, int lm);
        longint unsigned n;
        n = ((64'd1 << (k - 1 - c)) - 1) + (off >> (lm + c));
        return (chunk % CHUNKS) * NODE_ROW + int'(n & (NODE_ROW - 1));
    endfunction

    function automatic int unsigned slot_ix(int unsigned chunk, longint unsigned off, int lm);
        return (chunk % CHUNKS) * SLOT_ROW + int'((off >> lm) & (SLOT_ROW - 1));
    endfunction

    function automatic void list_push(int c, int unsigned s);
        int unsigned h;
        s = s % SLOTS;
        if (cls_valid[c]) begin
            h = cls_head[c] % SLOTS;
            link_next[s] = h;
            link_prev[h] = s;
        end else begin
            link_next[s] = s;
        end
        link_prev[s] = s;
        cls_head[c] = s;
        cls_valid[c] = 1'b1;
    endfunction

    function automatic int unsigned list_pop(int c);
        int unsigned s, n;
        s = cls_head[c] % SLOTS;
        n = link_next[s] % SLOTS;
        if (n != s) begin
            cls_head[c] = n;
            link_prev[n] = n;
        end else begin
            cls_valid[c] = 1'b0;
        end
        return s;
    endfunction

    function automatic void list_unlink(int c, int unsigned s);
        int unsigned p, n;
        bit hp, hn;
        s = s % SLOTS;
        p = link_prev[s] % SLOTS;
        n = link_next[s] % SLOTS;
        hp = (p != s);
        hn = (n != s);
        if (hp) link_next[p] = hn ? n : p;
        else if (hn) cls_head[c] = n;
        else cls_valid[c] = 1'b0;
        if (hn) link_prev[n] = hp ? p : n;
    endfunction

    // expected grant for one word; updates the mirror and the live-block list
    function automatic t_grant predict_grant(logic f, logic [31:0] size, logic [31:0] addr);
        int lm, k, c, j, top, cls0;
        int unsigned chunk, s;
        longint unsigned off, d, boff, half, usable, sz;
        int nd;
        bit size_ok, whole, got;
        t_grant g;
        lm = eff_lm();
        k = eff_k();
        top = lm + k - 1;
        sz = size;
        usable = (m_usable > CHUNKS) ? CHUNKS : m_usable;
        g.addr = 32'd0;
        g.status = ST_OK;
        for (c = 0; c < k; c++)
            if ((64'd1 << (lm + c)) >= sz) break;
        size_ok = (sz >= (64'd1 << lm)) && (c < k);
        if (f == FUNC_ALLOC) begin
            if (!size_ok) begin
                g.status = ST_SIZE;
            end else begin
                j = c;
                chunk = 0;
                off = 0;
                got = 1'b1;
                while (j < k && !cls_valid[j]) j++;
                if (j < k) begin
                    s = list_pop(j);
                    chunk = s / SLOT_ROW;
                    off = longint'(s % SLOT_ROW) << lm;
                end else if (rcy_cnt > 0) begin
                    chunk = rcy_head % CHUNKS;
                    rcy_head = rcy_link[chunk];
                    rcy_cnt--;
                    used_cnt++;
                    j = k - 1;
                end else if (fresh_idx < usable) begin
                    chunk = fresh_idx++;
                    used_cnt++;
                    j = k - 1;
                end else begin
                    got = 1'b0;
                    g.status = ST_OOM;
                end
                if (got) begin
                    node_used[node_ix(chunk, j, off, k, lm)] = 1'b1;
                    while (j > c) begin
                        j--;
                        node_used[node_ix(chunk, j, off, k, lm)] = 1'b1;
                        list_push(j, slot_ix(chunk, off + (64'd1 << (lm + j)), lm));
                    end
                    g.addr = 32'(longint'(m_base) + (longint'(chunk) << top) + off);
                    live_q.push_back('{g.addr, c});
                end
            end
        end else begin
            d = longint'(addr) - longint'(m_base);
            if (addr < m_base || (d >> top) >= fresh_idx) begin
                g.status = ST_ADDR;
            end else if (!size_ok) begin
                g.status = ST_SIZE;
            end else begin
                chunk = int'(d >> top);
                off = d & ((64'd1 << top) - 1);
                nd = node_ix(chunk, c, off, k, lm);
                whole = node_used[nd];
                if (c > 0 && whole) begin
                    half = 64'd1 << (lm + c - 1);
                    whole = !node_used[node_ix(chunk, c - 1, off, k, lm)] &&
                            !node_used[node_ix(chunk, c - 1, off + half, k, lm)];
                end
                if ((off & ((64'd1 << (lm + c)) - 1)) != 0 || !whole) begin
                    g.status = ST_ADDR;
                end else begin
                    cls0 = c;
                    node_used[nd] = 1'b0;
                    // merge upward while the buddy is free
                    forever begin
                        if (c >= k - 1) begin
                            rcy_link[chunk % CHUNKS] = rcy_head;
                            rcy_head = chunk % CHUNKS;
                            rcy_cnt++;
                            if (used_cnt > 0) used_cnt--;
                            break;
                        end
                        boff = off ^ (64'd1 << (lm + c));
                        if (!node_used[node_ix(chunk, c, boff, k, lm)]) begin
                            list_unlink(c, slot_ix(chunk, boff, lm));
                            if (boff < off) off = boff;
                            c++;
                            node_used[node_ix(chunk, c, off, k, lm)] = 1'b0;
                        end else begin
                            list_push(c, slot_ix(chunk, off, lm));
                            break;
                        end
                    end
                    foreach (live_q[i])
                        if (live_q[i].addr == addr && live_q[i].cls == cls0) begin
                            live_q.delete(i);
                            break;
                        end
                end
            end
        end
        g.chunks = 7'(used_cnt);
        return g;
    endfunction

    // one request word; called at a rising edge, returns at the accepting edge or after a gap
    task automatic send_word(logic f, logic [31:0] size, logic [31:0] addr,
                             bit typed = 1'b0, t_grant typed_g = '{0, 0, 0});
        t_grant g;
        i_func          <= f;
        i_request_size  <= size;
        i_block_address <= addr;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy);
        g = predict_grant(f, size, addr);
        grant_q.push_back(typed ? typed_g : g);
        if (!calm && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic flush();
        start <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [31:0] class_size(int c, int lm);
        if (c == 0) return 32'd1 << lm;
        return (32'd1 << (lm + c - 1)) + $urandom_range(1, 32'd1 << (lm + c - 1));
    endfunction

    // release every live block so a new layout starts from an empty tree
    task automatic free_all();
        int n;
        t_live_blk b;
        while (live_q.size() != 0) begin
            b = live_q[0];
            n = live_q.size();
            send_word(FUNC_FREE, class_size(b.cls, eff_lm()), b.addr);
            if (live_q.size() == n) void'(live_q.pop_front());
        end
        flush();
    endtask

    task automatic write_regs(logic [4:0] lm, logic [3:0] k, logic [6:0] us, logic [31:0] base);
        logic [1:0] idx;
        for (int r = 0; r < 4; r++) begin
            idx = 2'(r);
            i_cfg_we  <= 1'b1;
            i_cfg_idx <= idx;
            case (idx)
                REG_LMIN:   begin i_cfg_data <= {27'd0, lm}; m_lmin   = lm;   end
                REG_KCNT:   begin i_cfg_data <= {28'd0, k};  m_kcnt   = k;    end
                REG_USABLE: begin i_cfg_data <= {25'd0, us}; m_usable = us;   end
                default:    begin i_cfg_data <= base;        m_base   = base; end
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int n);
        int r, lm, k, i;
        for (int t = 0; t < n; t++) begin
            lm = eff_lm();
            k = eff_k();
            r = $urandom_range(0, 99);
            if (r < 50 || (live_q.size() == 0 && r < 85)) begin
                send_word(FUNC_ALLOC, class_size($urandom_range(0, k - 1), lm), $urandom);
            end else if (r < 85) begin
                i = $urandom_range(0, live_q.size() - 1);
                send_word(FUNC_FREE, class_size(live_q[i].cls, lm), live_q[i].addr);
            end else if (r < 93 || live_q.size() == 0) begin
                send_word(1'($urandom), $urandom, $urandom);
            end else begin
                // free off the block boundary
                i = $urandom_range(0, live_q.size() - 1);
                send_word(FUNC_FREE, class_size(live_q[i].cls, lm),
                          live_q[i].addr + (32'd1 << lm));
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : chk
        t_grant g;
        if (i_rst_n && o_done) begin
            if (grant_q.size() == 0) begin
                $display("%0t: result with nothing expected: addr=%h status=%0d chunks=%0d",
                         $time, o_granted_address, o_status, o_chunks_in_use);
                errors++;
            end else begin
                g = grant_q.pop_front();
                if (o_granted_address !== g.addr) begin
                    $display("%0t: granted_address expected %h actual %h",
                             $time, g.addr, o_granted_address);
                    errors++;
                end
                if (o_status !== g.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, g.status, o_status);
                    errors++;
                end
                if (o_chunks_in_use !== g.chunks) begin
                    $display("%0t: chunks_in_use expected %0d actual %0d",
                             $time, g.chunks, o_chunks_in_use);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : main
        t_dir_row  rows[17];
        int        ph_lm[6] = '{4, 0, 31, 10, 24, 6};
        int        ph_k[6]  = '{8, 2, 2, 15, 3, 5};
        int        ph_us[6] = '{64, 3, 127, 1, 0, 40};
        int        lme, ke, top;
        longint    slots;
        logic [31:0] base;

        rows = '{
            '{FUNC_ALLOC, 32'd16,         32'd0,         1'b1, '{32'd0,    ST_OK,   7'd1}},
            '{FUNC_ALLOC, 32'd0,          32'd0,         1'b1, '{32'd0,    ST_SIZE, 7'd1}},
            '{FUNC_ALLOC, 32'd15,         32'd0,         1'b1, '{32'd0,    ST_SIZE, 7'd1}},
            '{FUNC_ALLOC, 32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, '{32'd0,    ST_SIZE, 7'd1}},
            '{FUNC_ALLOC, 32'd2049,       32'd0,         1'b1, '{32'd0,    ST_SIZE, 7'd1}},
            '{FUNC_ALLOC, 32'd2048,       32'd0,         1'b1, '{32'd2048, ST_OK,   7'd2}},
            '{FUNC_FREE,  32'd16,         32'hFFFF_FFFF, 1'b1, '{32'd0,    ST_ADDR, 7'd2}},
            '{FUNC_FREE,  32'd2048,       32'd2048,      1'b1, '{32'd0,    ST_OK,   7'd1}},
            // double free
            '{FUNC_FREE,  32'd2048,       32'd2048,      1'b1, '{32'd0,    ST_ADDR, 7'd1}},
            // misaligned
            '{FUNC_FREE,  32'd16,         32'd8,         1'b1, '{32'd0,    ST_ADDR, 7'd1}},
            '{FUNC_FREE,  32'd0,          32'd0,         1'b1, '{32'd0,    ST_SIZE, 7'd1}},
            '{FUNC_ALLOC, 32'd17,         32'd0,         1'b0, '{0, 0, 0}},
            '{FUNC_ALLOC, 32'd1024,       32'd0,         1'b0, '{0, 0, 0}},
            // parent of a live block is not a whole block
            '{FUNC_FREE,  32'd32,         32'd0,         1'b0, '{0, 0, 0}},
            '{FUNC_ALLOC, 32'd2048,       32'd0,         1'b0, '{0, 0, 0}},
            '{FUNC_FREE,  32'd16,         32'd0,         1'b0, '{0, 0, 0}},
            '{FUNC_FREE,  32'h5555_5555,  32'hAAAA_AAAA, 1'b0, '{0, 0, 0}}
        };

        start           <= 1'b0;
        i_func          <= FUNC_ALLOC;
        i_request_size  <= 32'd0;
        i_block_address <= 32'd0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_LMIN;
        i_cfg_data      <= 32'd0;
        i_rst_n         <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // node rows are cleared after reset
        while (busy) @(posedge i_clk);

        foreach (rows[i])
            send_word(rows[i].f, rows[i].size, rows[i].addr, rows[i].typed, rows[i].g);
        free_all();

        for (int p = 0; p < 6; p++) begin
            lme = (ph_lm[p] < 4) ? 4 : ((ph_lm[p] > 24) ? 24 : ph_lm[p]);
            ke = (ph_k[p] < 2) ? 2 : ((ph_k[p] > CLASSES) ? CLASSES : ph_k[p]);
            top = lme + ke - 1;
            // keep every chunk of the region below the top of the address space
            slots = (64'd1 << (32 - top)) - CHUNKS;
            base = 32'(longint'($urandom_range(0, 32'(slots))) << top);
            write_regs(5'(ph_lm[p]), 4'(ph_k[p]), 7'(ph_us[p]), base);
            calm = (p == 5);
            run_phase(130);
            if (p < 5) free_all();
        end
        flush();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
